// ===== rtl/tlpq_pkg.sv =====
// Package for the three-level strict-priority queue.
// Holds the opcode and status codes and the decision struct shared by the modules.
// No dependencies.
package tlpq_pkg;

  localparam int unsigned NUM_LEVELS = 3;

  typedef logic [1:0] level_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADLVL = 2'd3
  } status_t;

  // Outcome of one beat as decided by the pointer unit.
  typedef struct packed {
    logic    do_push;
    logic    do_pop;
    level_t  lvl;
    status_t status;
  } dec_t;

endpackage

// ===== rtl/tlpq_ctrl.sv =====
// Pointer and fill-count unit of the three-level strict-priority queue.
// Decides each beat's outcome and keeps head, tail and count per level.
// Depends on tlpq_pkg.
module tlpq_ctrl #(
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic                             opcode,
  input  tlpq_pkg::level_t                 push_level,
  output tlpq_pkg::dec_t                   dec,
  output logic [$clog2(LEVEL_DEPTH)-1:0]   slot_idx
);
  import tlpq_pkg::*;

  localparam int unsigned IDX_W = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W = $clog2(LEVEL_DEPTH + 1);

  logic [IDX_W-1:0] head_r [NUM_LEVELS];
  logic [IDX_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] count_r [NUM_LEVELS];

  // Wrap a slot index back to zero after the last slot.
  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(LEVEL_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Decide the outcome: push target check, or lowest non-empty level for a pop.
  always_comb begin
    dec          = '0;
    dec.status   = ST_OK;
    slot_idx     = '0;
    if (opcode == OP_PUSH) begin
      if (push_level == level_t'(NUM_LEVELS)) begin
        dec.status = ST_BADLVL;
      end else begin
        dec.lvl = push_level;
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (push_level == level_t'(l)) begin
            slot_idx = tail_r[l];
            if (count_r[l] == CNT_W'(LEVEL_DEPTH)) begin
              dec.status = ST_FULL;
            end else begin
              dec.do_push = 1'b1;
            end
          end
        end
      end
    end else begin
      dec.status = ST_EMPTY;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
        if (count_r[l] != '0) begin
          dec.do_pop = 1'b1;
          dec.lvl    = level_t'(l);
          dec.status = ST_OK;
          slot_idx   = head_r[l];
        end
      end
    end
  end

  // Advance the pointers of the level touched by an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else if (fire) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (dec.lvl == level_t'(l)) begin
          if (dec.do_push) begin
            tail_r[l]  <= bump(tail_r[l]);
            count_r[l] <= count_r[l] + CNT_W'(1);
          end else if (dec.do_pop) begin
            head_r[l]  <= bump(head_r[l]);
            count_r[l] <= count_r[l] - CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/three_level_priority_fifo.sv =====
// Three-level strict-priority queue: one result beat per input beat.
// The result is registered and valid in the cycle after input acceptance; one beat is
// accepted every cycle while the result register is empty or being drained.
// The single-port value store is read or written at most once per accepted beat.
// Reset clears all pointers and fill counts; store contents are left as is.
// Depends on tlpq_pkg and tlpq_ctrl.
module three_level_priority_fifo #(
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_push_value,
  input  logic [1:0]         in_push_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_served_level,
  output logic [1:0]         out_status
);
  import tlpq_pkg::*;

  localparam int unsigned IDX_W  = $clog2(LEVEL_DEPTH);
  localparam int unsigned DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic                         fire;
  dec_t                         dec;
  logic [IDX_W-1:0]             slot_idx;
  logic [ADDR_W-1:0]            mem_addr;
  logic signed [VALUE_BITS-1:0] store_val;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_r;
  logic                         out_valid_r;
  logic                         popped_r;
  level_t                       served_r;
  status_t                      status_r;

  // Handshake: take a beat whenever the result register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  tlpq_ctrl #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .opcode     (in_opcode),
    .push_level (in_push_level),
    .dec        (dec),
    .slot_idx   (slot_idx)
  );

  // Flat store address: level base plus slot.
  assign mem_addr  = ADDR_W'(ADDR_W'(dec.lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(slot_idx);
  assign store_val = VALUE_BITS'(in_push_value);

  // Value store, at most one access per accepted beat; read data is registered.
  always_ff @(posedge clk) begin
    if (fire && dec.do_push) begin
      mem[mem_addr] <= store_val;
    end
    if (fire && dec.do_pop) begin
      rd_r <= mem[mem_addr];
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      popped_r    <= 1'b0;
      served_r    <= '0;
      status_r    <= ST_OK;
    end else if (fire) begin
      out_valid_r <= 1'b1;
      popped_r    <= dec.do_pop;
      served_r    <= dec.lvl;
      status_r    <= dec.status;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pop_value    = popped_r ? 32'(rd_r) : '0;
  assign out_served_level = served_r;
  assign out_status       = status_r;

  // A beat never both writes and reads the store.
  a_push_xor_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(dec.do_push && dec.do_pop))
    else $error("push and pop decided in the same beat");

  // An empty pop or an invalid level reports level zero and no value.
  a_no_level_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_BADLVL)
      |-> out_served_level == '0 && out_pop_value == '0)
    else $error("failed beat reports a level or value");

  // Only a successful pop returns a value.
  a_value_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !popped_r |-> out_pop_value == '0)
    else $error("non-pop beat carries a value");

  // Result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
